### rtl/core/wat_pkg.sv
// ============================================================================
// wat_pkg: shared types and constants
// Widths, register indexes and the per-item control word for the
// sliding-window threshold counter.
// ============================================================================
package wat_pkg;

    // Configuration port
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_WINDOW_LEN = t_cfg_idx'(0);
    localparam t_cfg_idx REG_THRESHOLD  = t_cfg_idx'(1);

    localparam int WLEN_BITS   = 7;
    localparam int THRESH_BITS = 16;

    localparam logic [WLEN_BITS-1:0]   WLEN_RESET   = WLEN_BITS'(3);
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(4);

    // Running sum wraps modulo 2^SUM_BITS
    localparam int SUM_BITS = 22;
    localparam int HIT_BITS = 32;

    typedef logic [SUM_BITS-1:0] t_sum;
    typedef logic [SUM_BITS:0]   t_need;
    typedef logic [HIT_BITS-1:0] t_hits;

    // Any required sum at or above 2^SUM_BITS can never be met
    localparam t_need NEED_SAT = {1'b1, {SUM_BITS{1'b0}}};
    localparam t_hits HIT_MAX  = {HIT_BITS{1'b1}};

    // Control word that travels with an item through the sum pipeline
    typedef struct packed {
        logic  drop_old;  // subtract the sample leaving the window
        logic  win_full;  // a full window ends at this item
        logic  last;      // final element of the array
        t_need need;      // threshold * window length, saturated
    } t_item_ctl;

endpackage

### rtl/core/wat_if.sv
// ============================================================================
// wat_if: stream and configuration interfaces
// Valid/ready channels for samples, results and register writes.
// ============================================================================
interface wat_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface wat_result_if;
    logic                 valid;
    logic                 ready;
    logic                 qualifies;
    wat_pkg::t_hits       hit_count;
    logic                 done_res;

    modport source (output valid, output qualifies, output hit_count, output done_res,
                    input ready);
    modport sink   (input valid, input qualifies, input hit_count, input done_res,
                    output ready);
endinterface

interface wat_cfg_if;
    logic                              valid;
    logic                              ready;
    wat_pkg::t_cfg_idx                 index;
    logic [wat_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/wat_cfg_regs.sv
// ============================================================================
// wat_cfg_regs: configuration registers
// Holds window length and threshold; writes are always taken.
// ============================================================================
module wat_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    wat_cfg_if.sink                             i_cfg,
    output logic [wat_pkg::WLEN_BITS-1:0]       o_window_len,
    output logic [wat_pkg::THRESH_BITS-1:0]     o_threshold
);

    logic [wat_pkg::WLEN_BITS-1:0]   r_window_len;
    logic [wat_pkg::THRESH_BITS-1:0] r_threshold;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= wat_pkg::WLEN_RESET;
            r_threshold  <= wat_pkg::THRESH_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                wat_pkg::REG_WINDOW_LEN: r_window_len <= i_cfg.data[wat_pkg::WLEN_BITS-1:0];
                wat_pkg::REG_THRESHOLD:  r_threshold  <= i_cfg.data[wat_pkg::THRESH_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_window_len = r_window_len;
    assign o_threshold  = r_threshold;

endmodule

### rtl/core/wat_ring_mem.sv
// ============================================================================
// wat_ring_mem: sample ring store
// One write port, one read port with registered data (read-first).
// ============================================================================
module wat_ring_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // Same-address read and write return the old entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/wat_window_ctl.sv
// ============================================================================
// wat_window_ctl: window position tracking
// Write slot, fill level, leaving-sample address and required sum;
// holds the item in stage 1 until the accumulator takes it.
// ============================================================================
module wat_window_ctl #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    wat_sample_if.sink                          i_in,
    input  logic [wat_pkg::WLEN_BITS-1:0]       i_window_len,
    input  logic [wat_pkg::THRESH_BITS-1:0]     i_threshold,
    input  logic                                i_s2_free,
    output logic                                o_accept,
    output logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] o_wr_addr,
    output logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] o_rd_addr,
    output logic                                o_s1_valid,
    output wat_pkg::t_item_ctl                  o_s1_ctl,
    output logic [SAMPLE_BITS-1:0]              o_s1_sample
);

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int KW = $clog2(WINDOW_MAX + 1);
    localparam int PW = wat_pkg::THRESH_BITS + KW;

    logic [AW-1:0] r_slot, n_slot;
    logic [KW-1:0] r_fill, n_fill;
    logic          r_v1;
    wat_pkg::t_item_ctl     r_ctl1;
    logic [SAMPLE_BITS-1:0] r_sample1;

    logic [KW-1:0] k;
    logic [KW-1:0] fill_inc;
    logic [KW-1:0] old_pos;
    logic [PW-1:0] prod;
    wat_pkg::t_item_ctl ctl0;
    logic          accept;

    assign i_in.ready = !r_v1 || i_s2_free;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        // Effective window length: zero acts as one, clamp to store depth
        if (i_window_len == '0) begin
            k = KW'(1);
        end else if (32'(i_window_len) > WINDOW_MAX) begin
            k = KW'(WINDOW_MAX);
        end else begin
            k = KW'(i_window_len);
        end

        fill_inc = (r_fill < KW'(WINDOW_MAX)) ? (r_fill + KW'(1)) : r_fill;

        if (KW'(r_slot) >= k) begin
            old_pos = KW'(r_slot) - k;
        end else begin
            old_pos = KW'(r_slot) + KW'(WINDOW_MAX) - k;
        end

        prod = PW'(i_threshold) * PW'(k);

        ctl0.drop_old = (r_fill >= k);
        ctl0.win_full = (fill_inc >= k);
        ctl0.last     = i_in.last;
        ctl0.need     = (prod >= wat_pkg::NEED_SAT) ? wat_pkg::NEED_SAT
                                                    : wat_pkg::t_need'(prod);

        n_slot = (r_slot == AW'(WINDOW_MAX - 1)) ? '0 : (r_slot + AW'(1));
        n_fill = i_in.last ? '0 : fill_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_fill <= '0;
            r_v1   <= 1'b0;
        end else begin
            if (accept) begin
                r_slot <= n_slot;
                r_fill <= n_fill;
                r_v1   <= 1'b1;
            end else if (i_s2_free) begin
                r_v1   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctl1    <= ctl0;
            r_sample1 <= i_in.sample;
        end
    end

    assign o_accept    = accept;
    assign o_wr_addr   = r_slot;
    assign o_rd_addr   = AW'(old_pos);
    assign o_s1_valid  = r_v1;
    assign o_s1_ctl    = r_ctl1;
    assign o_s1_sample = r_sample1;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= KW'(WINDOW_MAX))
        else $error("fill level beyond store depth");

    a_fill_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.last |=> r_fill == '0)
        else $error("fill level not cleared after last item");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !i_s2_free |=> r_v1 && $stable(r_ctl1))
        else $error("stalled item lost in stage 1");

endmodule

### rtl/core/wat_accum.sv
// ============================================================================
// wat_accum: running sum, threshold compare and hit count
// Sum update in one stage, then compare and count into the result
// register.
// ============================================================================
module wat_accum #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s1_valid,
    input  wat_pkg::t_item_ctl     i_s1_ctl,
    input  logic [SAMPLE_BITS-1:0] i_s1_sample,
    input  logic [SAMPLE_BITS-1:0] i_old_sample,
    output logic                   o_s2_free,
    wat_result_if.source           o_out
);

    wat_pkg::t_sum      r_sum, n_sum;
    wat_pkg::t_sum      r_sum2;
    wat_pkg::t_item_ctl r_ctl2;
    logic               r_v2;
    wat_pkg::t_hits     r_hits, n_hits;
    logic               r_ov;
    logic               r_q;
    wat_pkg::t_hits     r_hits_o;
    logic               r_done;

    logic out_free;
    logic take1;
    logic take2;
    logic q2;

    assign out_free  = !r_ov || o_out.ready;
    assign o_s2_free = !r_v2 || out_free;
    assign take1     = i_s1_valid && o_s2_free;
    assign take2     = r_v2 && out_free;

    always_comb begin
        n_sum = r_sum + wat_pkg::t_sum'(i_s1_sample);
        if (i_s1_ctl.drop_old) begin
            n_sum = n_sum - wat_pkg::t_sum'(i_old_sample);
        end

        q2 = r_ctl2.win_full && ({1'b0, r_sum2} >= r_ctl2.need);
        n_hits = (q2 && (r_hits != wat_pkg::HIT_MAX)) ? (r_hits + 1'b1) : r_hits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_hits <= '0;
            r_v2   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (take1) begin
                r_sum <= i_s1_ctl.last ? '0 : n_sum;
                r_v2  <= 1'b1;
            end else if (out_free) begin
                r_v2  <= 1'b0;
            end
            if (take2) begin
                r_hits <= r_ctl2.last ? '0 : n_hits;
                r_ov   <= 1'b1;
            end else if (o_out.ready) begin
                r_ov   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take1) begin
            r_sum2 <= n_sum;
            r_ctl2 <= i_s1_ctl;
        end
        if (take2) begin
            r_q      <= q2;
            r_hits_o <= n_hits;
            r_done   <= r_ctl2.last;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.qualifies = r_q;
    assign o_out.hit_count = r_hits_o;
    assign o_out.done_res  = r_done;

    a_hit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_q |-> r_hits_o != '0)
        else $error("qualifying result with zero hit count");

    a_hits_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take2 && r_ctl2.last |=> r_hits == '0)
        else $error("hit count not cleared after last item");

    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take1 && i_s1_ctl.last |=> r_sum == '0)
        else $error("running sum not cleared after last item");

endmodule

### rtl/core/window_average_threshold_counter.sv
// ============================================================================
// window_average_threshold_counter: sliding-window sum threshold counter
// Path: stage-1 register, sum register, then the result register on o_out.
// Throughput: one item per cycle while o_out is ready; the ring store reads
//   the leaving sample at accept, then the sum updates, then compare and count.
// Reset: clears fill level, write slot, sum, hit count and the pipeline;
//   registers return to window_len 3, threshold 4. No store clearing pass.
// ============================================================================
module window_average_threshold_counter #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wat_sample_if.sink    i_in,
    wat_result_if.source  o_out,
    wat_cfg_if.sink       i_cfg
);

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    // Configuration; the user must write it only while the pipeline is empty, the block does not enforce this
    logic [wat_pkg::WLEN_BITS-1:0]   window_len;
    logic [wat_pkg::THRESH_BITS-1:0] threshold;

    // Store access issued by the window tracker at accept time
    logic                   accept;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic [SAMPLE_BITS-1:0] old_sample;

    // Stage-1 item handed to the accumulator
    logic                   s1_valid;
    wat_pkg::t_item_ctl     s1_ctl;
    logic [SAMPLE_BITS-1:0] s1_sample;
    logic                   s2_free;

    wat_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .o_window_len (window_len),
        .o_threshold  (threshold)
    );

    // Tracks where the window sits in the ring: the new sample goes to the
    // write slot, the leaving one is the effective window length behind it. The
    // leaving sample is only used when it was written earlier in this array.
    wat_window_ctl #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_window_len (window_len),
        .i_threshold  (threshold),
        .i_s2_free    (s2_free),
        .o_accept     (accept),
        .o_wr_addr    (wr_addr),
        .o_rd_addr    (rd_addr),
        .o_s1_valid   (s1_valid),
        .o_s1_ctl     (s1_ctl),
        .o_s1_sample  (s1_sample)
    );

    // Read and write share the accept cycle. With a full-depth window the
    // leaving entry is the one being overwritten; read-first returns the
    // old sample, so no forwarding is needed.
    wat_ring_mem #(
        .DEPTH (WINDOW_MAX),
        .AW    (AW),
        .DW    (SAMPLE_BITS)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in.sample),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (old_sample)
    );

    // Running sum, threshold compare, saturating hit count, result register
    wat_accum #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1_valid   (s1_valid),
        .i_s1_ctl     (s1_ctl),
        .i_s1_sample  (s1_sample),
        .i_old_sample (old_sample),
        .o_s2_free    (s2_free),
        .o_out        (o_out)
    );

endmodule
